>>> hdl/cps_pkg.sv
// Shared types and codes for the CPU process scheduler.
`default_nettype none
package cps_pkg;
  typedef enum logic [1:0] {
    CMD_READY  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SCHED  = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_RR   = 2'd1,
    POL_PRIO = 2'd2,
    POL_RSVD = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_READY  = 2'd1,
    ST_RUN    = 2'd2,
    ST_RSVD   = 2'd3
  } tstate_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DECIDE,
    S_RD_HEAD,
    S_DISPATCH,
    S_COMPACT,
    S_PUSH,
    S_OUT
  } fsm_t;

  // Fields are listed from the highest bit down, so running_valid lands in bit 0.
  typedef struct packed {
    logic [31:0] switch_count;
    logic [3:0] preempted_id;
    logic preempt_valid;
    logic switched;
    logic [3:0] running_id;
    logic running_valid;
  } result_t;
endpackage
`default_nettype wire

>>> hdl/cps_compare.sv
// Priority and stamp compare unit, used in the priority scan and in the check against the running task.
`default_nettype none
module cps_compare #(
  parameter int PRIO_BITS  = 8,
  parameter int STAMP_BITS = 32
) (
  input  wire logic [PRIO_BITS-1:0]  cand_prio,
  input  wire logic [STAMP_BITS-1:0] cand_stamp,
  input  wire logic [PRIO_BITS-1:0]  best_prio,
  input  wire logic [STAMP_BITS-1:0] best_stamp,
  output logic                       better,
  output logic                       prio_higher
);
  assign prio_higher = cand_prio > best_prio;
  assign better = prio_higher || (cand_prio == best_prio && cand_stamp < best_stamp);
endmodule
`default_nettype wire

>>> hdl/cpu_process_scheduler.sv
// Top level of the CPU process scheduler: sequencer, task table and ready queue.
// Commands are handled one at a time; s_tready is low while one is in work or a result waits.
// Make ready is handled in the decode step; remove runs the ready queue compaction.
// Schedule reads the queue head in queue order, or first runs the table scan in priority
// mode; table scan and queue compaction each go one entry per cycle. The result sits in an output
// register. Reset clears all task states, the queue count, the switch counter and the policy.
`default_nettype none
module cpu_process_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int PRIO_BITS  = 8,
  parameter int STAMP_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cmd[1:0], task_id[5:2], task_priority[13:6], now_cycle[45:14], zero fill
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // running_valid, running_id, switched, preempt_valid, preempted_id, switch_count, zero fill
  output logic [47:0]      m_tdata
);
  import cps_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [1:0] tstate [MAX_TASKS];
  logic [PRIO_BITS-1:0] prio_mem [MAX_TASKS];
  logic [STAMP_BITS-1:0] stamp_mem [MAX_TASKS];
  logic [IW-1:0] fifo_mem [MAX_TASKS];

  fsm_t state, state_next;
  logic [1:0] policy;
  logic [1:0] cmd;
  logic [3:0] tid;
  logic [PRIO_BITS-1:0] tprio;
  logic [STAMP_BITS-1:0] now;
  logic [CW-1:0] fifo_count;
  logic cpu_busy;
  logic [IW-1:0] cpu_task;
  logic [31:0] switches;
  logic sw, pv;
  logic [IW-1:0] pid;
  logic [CW-1:0] scan;
  logic [CW-1:0] wptr;
  logic have_best;
  logic [IW-1:0] best;
  logic [PRIO_BITS-1:0] best_prio;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [IW-1:0] rm_id;
  logic do_disp;
  logic [IW-1:0] disp_id;
  logic push_prev;
  logic [IW-1:0] prev;
  logic [PRIO_BITS-1:0] run_prio;
  logic better, prio_higher, run_lower;
  result_t res;

  logic [IW-1:0] scan_i;
  logic [IW-1:0] tid_i;
  logic tid_ok;
  assign scan_i = scan[IW-1:0];
  assign tid_ok = ({28'd0, tid} < 32'(MAX_TASKS));
  assign tid_i = IW'(tid);

  cps_compare #(.PRIO_BITS(PRIO_BITS), .STAMP_BITS(STAMP_BITS)) u_cmp (
    .cand_prio(prio_mem[scan_i]),
    .cand_stamp(stamp_mem[scan_i]),
    .best_prio(best_prio),
    .best_stamp(best_stamp),
    .better(better),
    .prio_higher(prio_higher)
  );
  cps_compare #(.PRIO_BITS(PRIO_BITS), .STAMP_BITS(STAMP_BITS)) u_cmp_run (
    .cand_prio(best_prio),
    .cand_stamp(best_stamp),
    .best_prio(run_prio),
    .best_stamp(best_stamp),
    .better(),
    .prio_higher(run_lower)
  );
  assign run_prio = prio_mem[cpu_task];

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign cfg_ready = (state == S_IDLE);
  assign m_tdata = {5'b00000, res};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid && s_tready) state_next = S_DECODE;
      S_DECODE: begin
        state_next = S_OUT;
        case (cmd)
          CMD_READY: state_next = S_OUT;
          CMD_REMOVE: if (tid_ok && tstate[tid_i] == ST_READY) state_next = S_COMPACT;
          default: begin
            if (cmd == CMD_SCHED || (policy == POL_RR && !cpu_busy)) begin
              if (policy == POL_PRIO) state_next = S_SCAN;
              else if (!cpu_busy && fifo_count != '0) state_next = S_RD_HEAD;
            end else if (policy == POL_RR && fifo_count != '0 &&
                         fifo_mem[0] != cpu_task) begin
              state_next = S_RD_HEAD;
            end
          end
        endcase
      end
      S_SCAN: if (scan == CW'(MAX_TASKS)) state_next = S_DECIDE;
      S_DECIDE: begin
        if (have_best && (!cpu_busy || run_lower)) state_next = S_DISPATCH;
        else state_next = S_OUT;
      end
      S_RD_HEAD: state_next = S_DISPATCH;
      S_DISPATCH: state_next = S_COMPACT;
      S_COMPACT: if (scan >= fifo_count) state_next = S_PUSH;
      S_PUSH: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      policy <= POL_FCFS;
      fifo_count <= '0;
      cpu_busy <= 1'b0;
      cpu_task <= '0;
      switches <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) tstate[i] <= ST_ABSENT;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) policy <= cfg_data;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd <= s_tdata[1:0];
            tid <= s_tdata[5:2];
            tprio <= PRIO_BITS'(s_tdata[13:6]);
            now <= STAMP_BITS'(s_tdata[45:14]);
            sw <= 1'b0;
            pv <= 1'b0;
            pid <= '0;
          end
        end
        S_DECODE: begin
          case (cmd)
            CMD_READY: begin
              if (tid_ok && tstate[tid_i] == ST_ABSENT) begin
                tstate[tid_i] <= ST_READY;
                prio_mem[tid_i] <= tprio;
                stamp_mem[tid_i] <= now;
                if (fifo_count < CW'(MAX_TASKS)) begin
                  fifo_mem[fifo_count[IW-1:0]] <= tid_i;
                  fifo_count <= fifo_count + 1'b1;
                end
              end
            end
            CMD_REMOVE: begin
              if (tid_ok) begin
                if (tstate[tid_i] == ST_READY) begin
                  rm_id <= tid_i;
                  do_disp <= 1'b0;
                  push_prev <= 1'b0;
                  scan <= '0;
                  wptr <= '0;
                end else if (tstate[tid_i] == ST_RUN) begin
                  cpu_busy <= 1'b0;
                  cpu_task <= '0;
                end
                tstate[tid_i] <= ST_ABSENT;
              end
            end
            default: begin
              if (cmd == CMD_SCHED || (policy == POL_RR && !cpu_busy)) begin
                if (policy == POL_PRIO) begin
                  scan <= '0;
                  have_best <= 1'b0;
                end else if (!cpu_busy && fifo_count != '0) begin
                  push_prev <= 1'b0;
                end
              end else if (policy == POL_RR && fifo_count != '0 &&
                           fifo_mem[0] != cpu_task) begin
                push_prev <= 1'b1;
                prev <= cpu_task;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (scan != CW'(MAX_TASKS)) begin
            if (tstate[scan_i] == ST_READY && (!have_best || better)) begin
              have_best <= 1'b1;
              best <= scan_i;
              best_prio <= prio_mem[scan_i];
              best_stamp <= stamp_mem[scan_i];
            end
            scan <= scan + 1'b1;
          end
        end
        S_DECIDE: begin
          if (have_best && (!cpu_busy || run_lower)) begin
            disp_id <= best;
            push_prev <= cpu_busy;
            prev <= cpu_task;
          end
        end
        S_RD_HEAD: begin
          disp_id <= fifo_mem[0];
        end
        S_DISPATCH: begin
          rm_id <= disp_id;
          do_disp <= 1'b1;
          scan <= '0;
          wptr <= '0;
        end
        S_COMPACT: begin
          if (scan < fifo_count) begin
            if (fifo_mem[scan_i] != rm_id) begin
              fifo_mem[wptr[IW-1:0]] <= fifo_mem[scan_i];
              wptr <= wptr + 1'b1;
            end
            scan <= scan + 1'b1;
          end else begin
            fifo_count <= wptr;
          end
        end
        S_PUSH: begin
          if (push_prev) begin
            tstate[prev] <= ST_READY;
            stamp_mem[prev] <= now;
            fifo_mem[fifo_count[IW-1:0]] <= prev;
            fifo_count <= fifo_count + 1'b1;
            pv <= 1'b1;
            pid <= prev;
          end
          if (do_disp) begin
            tstate[rm_id] <= ST_RUN;
            cpu_busy <= 1'b1;
            cpu_task <= rm_id;
            switches <= switches + 1'b1;
            sw <= 1'b1;
          end
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          res.running_valid <= cpu_busy;
          res.running_id <= cpu_busy ? 4'(cpu_task) : 4'd0;
          res.switched <= sw;
          res.preempt_valid <= pv;
          res.preempted_id <= pv ? 4'(pid) : 4'd0;
          res.switch_count <= switches;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !s_tready)
    else $error("input accepted while busy");
  assert property (@(posedge clk) disable iff (rst) (fifo_count <= CW'(MAX_TASKS)))
    else $error("ready queue overflow");
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
